### hw/rtl/vlan_tag_insert_strip_unit_macros.svh
// assertion macros for the vlan tag insert/strip unit
// no dependencies; included by the top level
`ifndef VLAN_TAG_INSERT_STRIP_UNIT_MACROS_SVH
`define VLAN_TAG_INSERT_STRIP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VTIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define VTIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/vtis_pkg.sv
// shared types and constants for the vlan tag insert/strip unit
// no dependencies; used by every rtl module of the block
`default_nettype none

package vtis_pkg;

   localparam int LEN_W        = 15;
   localparam int VID_W        = 12;
   localparam int PRIO_W       = 3;
   localparam int BYTE_W       = 8;
   localparam int TCI_W        = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 15;

   localparam logic [LEN_W-1:0] MAX_FRAME_LEN  = LEN_W'(16384);
   localparam logic [LEN_W-1:0] ETH_HEADER_LEN = LEN_W'(14);
   localparam logic [LEN_W-1:0] STRIP_MIN_LEN  = LEN_W'(18);
   localparam logic [LEN_W-1:0] TAG_OFFSET     = LEN_W'(12);
   localparam logic [LEN_W-1:0] TAG_LEN        = LEN_W'(4);
   localparam logic [LEN_W-1:0] CAP_RESET      = LEN_W'(16388);
   localparam logic [VID_W-1:0] VID_RESET      = VID_W'(1);

   localparam logic [BYTE_W-1:0] TPID_HI = 8'h81;
   localparam logic [BYTE_W-1:0] TPID_LO = 8'h00;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // tag burst: four tag bytes then the frame byte
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PHASE_BYTE = PHASE_W'(4);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_UNTAGGED = 2'd2,
      STATUS_OVER     = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIP_MODE   = 2'd0,
      CSR_PORT_VID     = 2'd1,
      CSR_PORT_PRIO    = 2'd2,
      CSR_OUT_CAPACITY = 2'd3
   } csr_index_type;

   // one front decision, expanded by the back into one or five results
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_byte;
      logic              last;
      status_type        status;
      logic [LEN_W-1:0]  length;
      logic [VID_W-1:0]  vlan_id;
      logic              add_tag;
      logic [TCI_W-1:0]  tci;
   } desc_type;

   // settings seen by the front
   typedef struct packed {
      logic              strip_mode;
      logic [VID_W-1:0]  port_vlan_id;
      logic [PRIO_W-1:0] port_priority;
      logic [LEN_W-1:0]  out_capacity;
   } cfg_type;

endpackage

`default_nettype wire

### hw/rtl/vtis_queue.sv
// small flip-flop fifo of front decisions
// depends on vtis_pkg
`default_nettype none

module vtis_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire vtis_pkg::desc_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output vtis_pkg::desc_type      head,
   output logic                    empty
);
   import vtis_pkg::*;

   desc_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vtis_front.sv
// front: accepts frame bytes, tracks position and tag state, decides results
// depends on vtis_pkg
`default_nettype none

module vtis_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire vtis_pkg::cfg_type          cfg,
   input  wire logic                       accept,
   input  wire logic [vtis_pkg::BYTE_W-1:0] in_byte,
   input  wire logic                       in_last,
   output logic                            push,
   output vtis_pkg::desc_type              push_data
);
   import vtis_pkg::*;

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic             tpid_ok_ff, tpid_ok_in;
   logic             tag_found_ff, tag_found_in;
   logic [VID_W-1:0] vid_ff, vid_in;

   logic [LEN_W-1:0] flen;
   logic [LEN_W:0]   flen_plus;
   logic [LEN_W-1:0] flen_minus;
   logic             emit;
   desc_type         d;

   assign flen       = (pos_ff == MAX_FRAME_LEN) ? pos_ff : pos_ff + LEN_W'(1);
   assign flen_plus  = {1'b0, flen} + {1'b0, TAG_LEN};
   assign flen_minus = flen - TAG_LEN;

   always_comb begin
      tpid_ok_in   = tpid_ok_ff;
      tag_found_in = tag_found_ff;
      vid_in       = vid_ff;
      pos_in       = pos_ff;
      emit         = 1'b1;

      d           = '0;
      d.data_byte = in_byte;
      d.last      = in_last;
      d.tci       = {cfg.port_priority, 1'b0, cfg.port_vlan_id};
      d.add_tag   = !cfg.strip_mode && (pos_ff == TAG_OFFSET);

      // strip mode swallows the four tag bytes
      if (cfg.strip_mode) begin
         if (pos_ff == TAG_OFFSET) begin
            tpid_ok_in = (in_byte == TPID_HI);
            emit       = 1'b0;
         end else if (pos_ff == TAG_OFFSET + LEN_W'(1)) begin
            tag_found_in = tpid_ok_ff && (in_byte == TPID_LO);
            emit         = 1'b0;
         end else if (pos_ff == TAG_OFFSET + LEN_W'(2)) begin
            vid_in = {in_byte[3:0], 8'h00};
            emit   = 1'b0;
         end else if (pos_ff == TAG_OFFSET + LEN_W'(3)) begin
            vid_in = {vid_ff[VID_W-1:8], in_byte};
            emit   = 1'b0;
         end
      end

      d.has_byte = emit;
      if (!emit) begin
         d.data_byte = '0;
      end

      if (in_last) begin
         if (cfg.strip_mode) begin
            priority if (flen < STRIP_MIN_LEN) begin
               d.status = STATUS_SHORT;
            end else if (!tag_found_ff) begin
               d.status = STATUS_UNTAGGED;
            end else begin
               d.vlan_id = vid_ff;
               if (flen_minus > cfg.out_capacity) begin
                  d.status = STATUS_OVER;
               end else begin
                  d.length = flen_minus;
               end
            end
         end else begin
            priority if (flen < ETH_HEADER_LEN) begin
               d.status = STATUS_SHORT;
            end else if (flen_plus > {1'b0, cfg.out_capacity}) begin
               d.status = STATUS_OVER;
            end else begin
               d.length = flen_plus[LEN_W-1:0];
            end
         end
         pos_in       = '0;
         tpid_ok_in   = 1'b0;
         tag_found_in = 1'b0;
         vid_in       = '0;
      end else if (pos_ff < MAX_FRAME_LEN) begin
         pos_in = pos_ff + LEN_W'(1);
      end
   end

   assign push      = accept && (emit || in_last);
   assign push_data = d;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tpid_ok_ff   <= 1'b0;
         tag_found_ff <= 1'b0;
         vid_ff       <= '0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         tpid_ok_ff   <= tpid_ok_in;
         tag_found_ff <= tag_found_in;
         vid_ff       <= vid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vtis_back.sv
// back: expands queued decisions into results, tag burst first
// depends on vtis_pkg
`default_nettype none

module vtis_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vtis_pkg::desc_type   head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output vtis_pkg::desc_type        rsp_data
);
   import vtis_pkg::*;

   logic                 valid_ff, valid_in;
   desc_type             out_ff, out_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 load;
   logic [BYTE_W-1:0]    tag_byte;

   assign load = (!valid_ff || rsp_ready) && !empty;

   always_comb begin
      unique case (phase_ff[1:0])
         2'd0: tag_byte = TPID_HI;
         2'd1: tag_byte = TPID_LO;
         2'd2: tag_byte = head.tci[TCI_W-1:8];
         2'd3: tag_byte = head.tci[7:0];
         default: tag_byte = TPID_HI;
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      out_in   = out_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head.add_tag && (phase_ff != PHASE_BYTE)) begin
            out_in           = '0;
            out_in.data_byte = tag_byte;
            out_in.has_byte  = 1'b1;
            phase_in         = phase_ff + PHASE_W'(1);
         end else begin
            out_in   = head;
            phase_in = '0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

### hw/rtl/vlan_tag_insert_strip_unit.sv
// top level of the 802.1q vlan tag insert/strip unit
// depends on vtis_pkg, vtis_front, vtis_queue, vtis_back and the macros header
`default_nettype none
`include "vlan_tag_insert_strip_unit_macros.svh"

// Streams an Ethernet frame one byte per transfer and either inserts an
// 802.1Q tag in front of byte 12 (0x81 0x00 then the TCI built from the
// port priority, DEI 0 and the port VLAN id) or removes bytes 12-15 and
// reports the VLAN id found there. Each input transfer gives zero, one or
// (at the tag point in insert mode) five result transfers; the one marked
// out_last carries the frame status, the new length and, in strip mode, the
// seen VLAN id. A byte is taken every cycle while the four-entry decision
// queue has room; the result side gives at most one transfer per cycle, so
// the four extra tag bytes cost output time once per tagged frame. The
// queue takes up part of that: a sender running flat out sees req_ready
// drop for each tagged frame, and for longer when the queue already holds a
// backlog from the last tag. Each decision passes through the queue and
// the output register before it reaches the result port.
// Settings are written through the csr port, always ready, and must only
// change while no frame is in flight.
module vlan_tag_insert_strip_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input byte channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [vtis_pkg::BYTE_W-1:0]   req_in_byte,
   input  wire logic                          req_in_last,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [vtis_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_has_byte,
   output logic                               rsp_out_last,
   output logic [1:0]                         rsp_frame_status,
   output logic [vtis_pkg::LEN_W-1:0]         rsp_result_length,
   output logic [vtis_pkg::VID_W-1:0]         rsp_seen_vlan_id,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [vtis_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [vtis_pkg::CSR_DATA_W-1:0] csr_data
);
   import vtis_pkg::*;

   // settings registers
   cfg_type  cfg_ff, cfg_in;
   logic     csr_write;

   // front to queue, queue to back
   logic     req_accept;
   logic     q_push;
   desc_type q_push_data;
   logic     q_full;
   logic     q_pop;
   desc_type q_head;
   logic     q_empty;
   desc_type rsp_data;

   // csr port never stalls
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STRIP_MODE:   cfg_in.strip_mode    = csr_data[0];
            CSR_PORT_VID:     cfg_in.port_vlan_id  = csr_data[VID_W-1:0];
            CSR_PORT_PRIO:    cfg_in.port_priority = csr_data[PRIO_W-1:0];
            CSR_OUT_CAPACITY: cfg_in.out_capacity  = csr_data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_mode    <= 1'b0;
         cfg_ff.port_vlan_id  <= VID_RESET;
         cfg_ff.port_priority <= '0;
         cfg_ff.out_capacity  <= CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer whenever the queue has room for its decision
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   vtis_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (req_accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .push      (q_push),
      .push_data (q_push_data)
   );

   vtis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   vtis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // result payload ports
   assign rsp_out_byte      = rsp_data.data_byte;
   assign rsp_has_byte      = rsp_data.has_byte;
   assign rsp_out_last      = rsp_data.last;
   assign rsp_frame_status  = rsp_data.status;
   assign rsp_result_length = rsp_data.length;
   assign rsp_seen_vlan_id  = rsp_data.vlan_id;

   // a decision is never written into a full queue
   `VTIS_ASSERT_NOW(a_no_queue_overflow, clock, reset, q_push, !q_full, "queue overflow")

   // a status-only result only ever closes a frame
   `VTIS_ASSERT_NOW(a_bare_status_is_last, clock, reset, rsp_valid && !rsp_has_byte, rsp_out_last, "status-only result without last mark")

   // a failed frame reports no length
   `VTIS_ASSERT_NOW(a_fail_no_length, clock, reset, rsp_valid && (rsp_frame_status != STATUS_OK), rsp_result_length == '0, "length on failed frame")

   // a popped decision leaves the queue no fuller than before
   `VTIS_ASSERT_NEXT(a_pop_frees_slot, clock, reset, q_pop && !q_push, !q_full, "queue still full after pop")

endmodule

`default_nettype wire
